### rtl/channel_minmax_percent_normalizer_assert.svh
// Assertion macros used by the checker file cmmpn_checker.sv.
`ifndef CHANNEL_MINMAX_PERCENT_NORMALIZER_ASSERT_SVH
`define CHANNEL_MINMAX_PERCENT_NORMALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CMMPN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CMMPN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/cmmpn_pkg.sv
`default_nettype none

package cmmpn_pkg;

	// Fixed field widths
	localparam int CH_W   = 3;
	localparam int SMP_W  = 16;
	localparam int PCT_W  = 7;

	// Bound reset values and scale
	localparam int RESET_MIN  = 10000;
	localparam int RESET_MAX  = -10000;
	localparam int FULL_SCALE = 100;

	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [SMP_W-1:0] sample;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel_out;
		logic [PCT_W-1:0] percent;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_UPD  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

endpackage

`default_nettype wire

### rtl/cmmpn_bounds.sv
`default_nettype none

module cmmpn_bounds #(
	parameter int CHANNELS   = 8,
	parameter int VALUE_BITS = 16,
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [IW-1:0]                rd_idx,
	input  logic                         wr_en,
	input  logic [IW-1:0]                wr_idx,
	input  logic signed [VALUE_BITS-1:0] wr_lo,
	input  logic signed [VALUE_BITS-1:0] wr_hi,
	output logic signed [VALUE_BITS-1:0] rd_lo,
	output logic signed [VALUE_BITS-1:0] rd_hi
);
	import cmmpn_pkg::*;

	localparam logic signed [VALUE_BITS-1:0] LO_RST = VALUE_BITS'(RESET_MIN);
	localparam logic signed [VALUE_BITS-1:0] HI_RST = VALUE_BITS'(RESET_MAX);

	// {min, max} per channel
	logic [2*VALUE_BITS-1:0] mem [CHANNELS];
	logic [2*VALUE_BITS-1:0] rdata_q;
	logic [CHANNELS-1:0]     vld_q;
	logic                    rvld_q;

	// Storage write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_lo, wr_hi};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx];
		end
	end

	// Per-channel written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_idx];
			end
		end
	end

	// Never-written channel reads as its reset bounds
	assign rd_lo = rvld_q ? signed'(rdata_q[2*VALUE_BITS-1:VALUE_BITS]) : LO_RST;
	assign rd_hi = rvld_q ? signed'(rdata_q[VALUE_BITS-1:0]) : HI_RST;

endmodule

`default_nettype wire

### rtl/cmmpn_div.sv
`default_nettype none

module cmmpn_div #(
	parameter int DEN_BITS = 16,
	localparam int NW = DEN_BITS + cmmpn_pkg::PCT_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NW-1:0]               num,
	input  logic [DEN_BITS-1:0]         den,
	output logic                        done,
	output logic [cmmpn_pkg::PCT_W-1:0] quot
);
	import cmmpn_pkg::*;

	localparam int KW = $clog2(PCT_W + 1);

	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    dsh_q;
	logic [PCT_W-1:0] quot_q;
	logic [KW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	// One restoring step per cycle, quotient MSB first
	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (PCT_W - 1);
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[PCT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == KW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(PCT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

### rtl/channel_minmax_percent_normalizer.sv
// Path from item accept to result valid: read, update, 7 divide steps, result load,
// output register; a sample at the minimum skips the divide steps, and an out-of-range
// channel goes straight to result load. One item at a time: the next item is taken only
// once the last result is loaded, so the one-bit-per-cycle restoring divider and the
// bounds store read set the pace; a stalled result holds off the next item.
// Reset (arst_n low, async): all channels read min 10000 / max -10000, no result held.
`default_nettype none

module channel_minmax_percent_normalizer #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  cmmpn_pkg::in_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output cmmpn_pkg::out_t result
);
	import cmmpn_pkg::*;

	localparam int VW = (SAMPLE_BITS < SMP_W) ? SMP_W : SAMPLE_BITS;
	localparam int NW = VW + PCT_W;
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t                state_q;
	logic [CH_W-1:0]       ch_q;
	logic signed [VW-1:0]  smp_q;
	logic [PCT_W-1:0]      pct_q;
	out_t                  res_q;
	logic                  res_vld_q;

	logic signed [VW-1:0]  smp_wide;
	logic                  in_range;
	logic signed [VW-1:0]  rd_lo, rd_hi, lo_new, hi_new;
	logic [VW-1:0]         diff_w, span_w;
	logic [NW-1:0]         num;
	logic                  div_start, div_done;
	logic [PCT_W-1:0]      div_quot;
	logic                  res_load;

	// Sample widening to the bound width
	generate
		if (SAMPLE_BITS <= SMP_W) begin : g_sext
			logic signed [SAMPLE_BITS-1:0] smp_low;
			assign smp_low  = item.sample[SAMPLE_BITS-1:0];
			assign smp_wide = VW'(smp_low);
		end else begin : g_zext
			assign smp_wide = signed'(VW'(unsigned'(item.sample)));
		end
	endgenerate

	assign in_range = (32'(item.channel) < 32'(CHANNELS));

	// Bound update and percent numerator/denominator
	assign lo_new = (smp_q < rd_lo) ? smp_q : rd_lo;
	assign hi_new = (smp_q > rd_hi) ? smp_q : rd_hi;
	// both differences are non-negative and fit VW bits unsigned
	assign diff_w = smp_q - lo_new;
	assign span_w = hi_new - lo_new;
	assign num    = NW'(diff_w) * NW'(FULL_SCALE);

	assign div_start = (state_q == S_UPD) && (smp_q != lo_new);
	assign res_load  = (state_q == S_DONE) && (!res_vld_q || !result_stall);

	cmmpn_bounds #(
		.CHANNELS   (CHANNELS),
		.VALUE_BITS (VW)
	) u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (state_q == S_RD),
		.rd_idx (IW'(ch_q)),
		.wr_en  (state_q == S_UPD),
		.wr_idx (IW'(ch_q)),
		.wr_lo  (lo_new),
		.wr_hi  (hi_new),
		.rd_lo  (rd_lo),
		.rd_hi  (rd_hi)
	);

	cmmpn_div #(
		.DEN_BITS (VW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (span_w),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Item capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			ch_q  <= item.channel;
			smp_q <= smp_wide;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pct_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						pct_q   <= '0;
						state_q <= in_range ? S_RD : S_DONE;
					end
				end
				S_RD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= div_start ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						pct_q   <= div_quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.channel_out <= ch_q;
			res_q.percent     <= pct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_load) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

`default_nettype wire

### rtl/cmmpn_checker.sv
`default_nettype none
`include "channel_minmax_percent_normalizer_assert.svh"

module cmmpn_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            item_valid,
	input wire logic            item_stall,
	input wire cmmpn_pkg::in_t  item,
	input wire logic            result_valid,
	input wire logic            result_stall,
	input wire cmmpn_pkg::out_t result
);
	import cmmpn_pkg::*;

	// Percent never leaves its range
	`CMMPN_ASSERT_NOW(a_pct_range, result_valid, result.percent <= PCT_W'(FULL_SCALE), "percent above full scale")

	// One item at a time: busy right after an accept
	`CMMPN_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "item taken while busy")

	// A stalled result stays valid
	`CMMPN_ASSERT_NXT(a_res_hold, result_valid && result_stall, result_valid, "result dropped under stall")

	// A stalled result keeps its payload
	`CMMPN_ASSERT_NXT(a_res_stable, result_valid && result_stall, $stable(result), "result changed under stall")

endmodule

bind channel_minmax_percent_normalizer cmmpn_checker u_cmmpn_checker (.*);

`default_nettype wire

### tb/percent_checker.sv
// Watches both channels, predicts each percent and compares it with what the block returns.
module percent_checker
	import cmmpn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_stall,
	input  in_t  item,
	input  logic result_valid,
	input  logic result_stall,
	input  out_t result,
	input  logic run_done,
	output int   pending,
	output int   fault_count,
	output int   results_seen,
	output int   zero_hits,
	output int   full_hits
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS    = 8;
	localparam int PRINT_LIMIT = 25;

	// running bounds, one pair per channel
	logic signed [SMP_W-1:0] lowest [CHANNELS];
	logic signed [SMP_W-1:0] highest [CHANNELS];

	// percents still owed by the block, oldest first
	out_t percent_due[$];

	initial begin
		pending      = 0;
		fault_count  = 0;
		results_seen = 0;
		zero_hits    = 0;
		full_hits    = 0;
	end

	task automatic report_mismatch(input string msg);
		if (fault_count < PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		fault_count++;
	endtask

	// Widen the bounds of the addressed channel, then place the sample between them.
	function automatic out_t track_and_scale(input in_t x);
		out_t   r;
		int     ch;
		int     s;
		int     lo;
		int     hi;
		longint pct;
		ch            = x.channel;
		s             = x.sample;
		r.channel_out = x.channel;
		r.percent     = '0;
		if (ch < CHANNELS) begin
			if (s < lowest[ch])
				lowest[ch] = x.sample;
			if (s > highest[ch])
				highest[ch] = x.sample;
			lo = lowest[ch];
			hi = highest[ch];
			// sample at the minimum (flat channel included) stays at zero
			if (s != lo && hi > lo) begin
				pct = (longint'(s - lo) * FULL_SCALE) / longint'(hi - lo);
				if (pct > FULL_SCALE)
					pct = FULL_SCALE;
				r.percent = PCT_W'(pct);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				lowest[k]  = SMP_W'(RESET_MIN);
				highest[k] = SMP_W'(RESET_MAX);
			end
			percent_due.delete();
			pending <= 0;
		end else begin
			// retire the oldest expectation before queuing a new one
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result.percent == '0)
					zero_hits++;
				if (result.percent == PCT_W'(FULL_SCALE))
					full_hits++;
				if (percent_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result ch=%0d pct=%0d",
						result.channel_out, result.percent));
				end else begin
					want = percent_due.pop_front();
					if (result.channel_out !== want.channel_out)
						report_mismatch($sformatf("channel_out got %0d want %0d",
							result.channel_out, want.channel_out));
					if (result.percent !== want.percent)
						report_mismatch($sformatf("percent got %0d want %0d (ch %0d)",
							result.percent, want.percent, want.channel_out));
				end
			end
			if (item_valid && !item_stall)
				percent_due.push_back(track_and_scale(item));
			pending <= percent_due.size();
		end
	end

	// anything still owed once the run has drained is a failure
	always @(posedge run_done) begin
		if (percent_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", percent_due.size()));
	end

endmodule

### tb/tb_channel_minmax_percent_normalizer.sv
module tb_channel_minmax_percent_normalizer;
	import cmmpn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1250;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;

	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTY} rx_mode_t;

	logic clk          = 1'b0;
	logic arst_n       = 1'b0;
	logic item_valid   = 1'b0;
	logic item_stall;
	in_t  item         = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;
	logic run_done     = 1'b0;

	int pending;
	int checker_faults;
	int results_seen;
	int zero_hits;
	int full_hits;

	int quiet_cycles = 0;
	int stall_cycles = 0;
	int directed_cnt = 0;
	int random_cnt   = 0;

	// stimulus shaping only: last sample per channel and a home band for the low channels
	logic signed [SMP_W-1:0] last_sample [8];
	int band_mid [4] = '{50, 15000, -15000, 10000};

	rx_mode_t rx_mode   = RX_OPEN;
	int       rx_left   = 0;
	int       burst_left = 0;
	logic     stall_on  = 1'b0;

	channel_minmax_percent_normalizer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	percent_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.run_done     (run_done),
		.pending      (pending),
		.fault_count  (checker_faults),
		.results_seen (results_seen),
		.zero_hits    (zero_hits),
		.full_hits    (full_hits)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp);
		in_t x;
		x.channel   = ch;
		x.sample    = smp;
		item_valid <= 1'b1;
		item       <= x;
		last_sample[ch] = smp;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// Hold off the sender until every owed result is back.
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [SMP_W-1:0] clamp_sample(input int v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return SMP_W'(v);
	endfunction

	// Mix of corners, repeats of the last value, band values and full-range noise.
	function automatic logic signed [SMP_W-1:0] pick_sample(input int ch);
		int roll;
		int spread;
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			case ($urandom_range(0, 7))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return 16'sd0;
				3: return -16'sd1;
				4: return SMP_W'(RESET_MIN);
				5: return SMP_W'(RESET_MAX);
				6: return SMP_W'(RESET_MIN - 1);
				default: return SMP_W'(RESET_MAX + 1);
			endcase
		end
		if (roll < 20)
			return last_sample[ch];
		if (ch < 4 && roll < 90) begin
			spread = $urandom_range(0, 1) ? 200 : 3000;
			return clamp_sample(band_mid[ch] + int'($urandom_range(0, 2 * spread)) - spread);
		end
		return SMP_W'($urandom);
	endfunction

	// Receiver stalls: modes of random length, from open to long bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_left = 0;
		end else begin
			if (result_stall)
				stall_cycles++;
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(50, 300);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:  result_stall <= 1'b0;
				RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					if (burst_left == 0) begin
						stall_on   = ~stall_on;
						burst_left = $urandom_range(1, 25);
					end
					burst_left--;
					result_stall <= stall_on;
				end
			endcase
		end
	end

	// Watchdog: cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
		$display("tb_channel_minmax_percent_normalizer: errors");
		$finish;
	end

	initial begin
		int ch;
		int burst;
		int gap;
		for (int k = 0; k < 8; k++)
			last_sample[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flat channel, exact steps, reset bounds, full-scale span
		send_item(3'd0, 16'sd0);
		send_item(3'd0, 16'sd0);
		send_item(3'd0, 16'sd100);
		send_item(3'd0, 16'sd50);
		send_item(3'd0, 16'sd33);
		send_item(3'd0, 16'sd0);
		send_item(3'd1, 16'sd20000);
		send_item(3'd1, SMP_W'(RESET_MIN));
		send_item(3'd2, -16'sd20000);
		send_item(3'd2, SMP_W'(RESET_MAX));
		send_item(3'd3, SMP_W'(RESET_MIN));
		send_item(3'd4, 16'sh8000);
		send_item(3'd4, 16'sh7fff);
		send_item(3'd4, -16'sd1);
		send_item(3'd4, 16'sd0);
		send_item(3'd4, 16'sh8000);
		send_item(3'd5, 16'sh7fff);
		send_item(3'd5, 16'sh8000);
		send_item(3'd6, 16'sd1);
		send_item(3'd6, -16'sd1);
		send_item(3'd6, 16'sd0);
		send_item(3'd7, 16'sh5555);
		send_item(3'd7, 16'shaaaa);
		send_item(3'd7, 16'sh0f0f);
		directed_cnt = 24;
		drain_results();

		// random bursts; the first stretch runs without gaps
		while (random_cnt < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int b = 0; b < burst && random_cnt < RANDOM_ITEMS; b++) begin
				ch = $urandom_range(0, 7);
				send_item(CH_W'(ch), pick_sample(ch));
				random_cnt++;
				if (random_cnt == RANDOM_ITEMS / 2)
					drain_results();
			end
			gap = (random_cnt < 120 || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// drain, settle, then close out
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		run_done <= 1'b1;
		@(posedge clk);
		$display("covered %0d directed and %0d random samples over 8 channels",
			directed_cnt, random_cnt);
		$display("%0d results checked (%0d at zero, %0d at full scale), %0d stalled cycles",
			results_seen, zero_hits, full_hits, stall_cycles);
		if (checker_faults == 0)
			$display("tb_channel_minmax_percent_normalizer: clean");
		else
			$display("tb_channel_minmax_percent_normalizer: errors");
		$finish;
	end

endmodule
